/* sv/pwf_pkg.sv */
// ----------------------------------------------------------------------------
// pwf_pkg
// Shared constants, tables, types and saturation helpers of the plane-wave
// field evaluator.
// ----------------------------------------------------------------------------
package pwf_pkg;

  localparam int unsigned CordicStages = 24;
  localparam int unsigned ExpTerms     = 10;
  localparam int unsigned CordicDelay  = 32 - CordicStages;
  localparam int unsigned PDelay       = 34;
  localparam int unsigned PipeDepth    = 42;

  localparam logic signed [33:0] KGain   = 34'sd652032875;
  localparam logic [29:0]        Inv2Pi  = 30'd683565276;
  localparam logic signed [31:0] Log2E   = 32'sd1549082005;
  localparam logic [29:0]        Ln2     = 30'd744261118;
  localparam logic signed [63:0] ExpLim  = 64'sd274877906944;
  localparam logic [31:0]        HornOne = 32'h4000_0000;

  typedef enum logic [2:0] {
    CFG_WAVENUMBER = 3'd0,
    CFG_ADMITTANCE = 3'd1,
    CFG_AMP_X      = 3'd2,
    CFG_AMP_Y      = 3'd3,
    CFG_AMP_Z      = 3'd4,
    CFG_DIRECTION  = 3'd5
  } cfg_idx_e;

  localparam logic [31:0] AtanTurns [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // floor((2^32-1)/d) for d = 1..10
  localparam logic [31:0] Recip [10] = '{
    32'd4294967295, 32'd2147483647, 32'd1431655765, 32'd1073741823, 32'd858993459,
    32'd715827882,  32'd613566756,  32'd536870911,  32'd477218588,  32'd429496729
  };

  typedef struct packed {
    logic               neg;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cordic_t;

  typedef struct packed {
    logic [29:0] y;
    logic [31:0] r;
  } horner_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Q.44 value times 2^p to Q8.24, saturated
  function automatic logic [31:0] scale_out(input logic signed [63:0] v,
                                            input logic signed [9:0] p);
    logic signed [10:0] sh;
    logic signed [10:0] nsh;
    logic [5:0]         amt;
    logic [4:0]         k;
    logic signed [63:0] r;
    logic signed [63:0] lim_hi;
    logic signed [63:0] lim_lo;
    logic [31:0]        res;
    sh  = 11'sd20 - {p[9], p};
    nsh = -sh;
    if (!sh[10]) begin
      amt = (sh > 11'sd62) ? 6'd62 : sh[5:0];
      r   = v >>> amt;
      res = sat32(r);
    end else if (nsh > 11'sd31) begin
      if (v > 64'sd0) begin
        res = 32'h7FFF_FFFF;
      end else if (v < 64'sd0) begin
        res = 32'h8000_0000;
      end else begin
        res = 32'h0;
      end
    end else begin
      k      = nsh[4:0];
      lim_hi = 64'sd2147483647 >>> k;
      lim_lo = -(64'sd1 <<< (6'd31 - {1'b0, k}));
      r      = v <<< k;
      if (v > lim_hi) begin
        res = 32'h7FFF_FFFF;
      end else if (v < lim_lo) begin
        res = 32'h8000_0000;
      end else begin
        res = r[31:0];
      end
    end
    return res;
  endfunction

endpackage

/* sv/pwf_cordic_cell.sv */
// ----------------------------------------------------------------------------
// pwf_cordic_cell
// One registered CORDIC rotation step in turn units.
// ----------------------------------------------------------------------------
module pwf_cordic_cell (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [4:0]        stage_i,
  input  pwf_pkg::cordic_t  d_i,
  output pwf_pkg::cordic_t  d_o
);

  pwf_pkg::cordic_t   d_d, d_q;
  logic signed [33:0] dx, dy, ang;

  always_comb begin
    dx  = $signed(d_i.y) >>> stage_i;
    dy  = $signed(d_i.x) >>> stage_i;
    ang = $signed({2'b00, pwf_pkg::AtanTurns[stage_i]});
    d_d = d_i;
    if (!d_i.z[33]) begin
      d_d.x = d_i.x - dx;
      d_d.y = d_i.y + dy;
      d_d.z = d_i.z - ang;
    end else begin
      d_d.x = d_i.x + dx;
      d_d.y = d_i.y - dy;
      d_d.z = d_i.z + ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

/* sv/pwf_horner_cell.sv */
// ----------------------------------------------------------------------------
// pwf_horner_cell
// One Horner term of the exponential series: r = 1 + (r*y)/term, three stages.
// ----------------------------------------------------------------------------
module pwf_horner_cell (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [3:0]        term_i,
  input  pwf_pkg::horner_t  d_i,
  output pwf_pkg::horner_t  d_o
);

  logic [61:0] prod_q;
  logic [29:0] ya_q, yb_q, yc_q;
  logic [31:0] q, qb_q, db, dc, rc_q;
  logic [63:0] m_d, m_q;
  logic [35:0] dt, rem;

  assign q   = prod_q[61:30];
  assign m_d = q * pwf_pkg::Recip[term_i - 4'd1];

  always_comb begin
    db  = m_q[63:32];
    dt  = db * term_i;
    rem = {4'b0, qb_q} - dt;
    dc  = (rem >= {32'b0, term_i}) ? db + 32'd1 : db;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= d_i.r * d_i.y;
      ya_q   <= d_i.y;
      m_q    <= m_d;
      qb_q   <= q;
      yb_q   <= ya_q;
      rc_q   <= pwf_pkg::HornOne + dc;
      yc_q   <= yb_q;
    end
  end

  assign d_o = '{y: yc_q, r: rc_q};

endmodule

/* sv/pwf_field.sv */
// ----------------------------------------------------------------------------
// pwf_field
// Complex product of a field weight and the phase factor, scaled by 2^p.
// ----------------------------------------------------------------------------
module pwf_field (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] w_re_i,
  input  logic signed [31:0] w_im_i,
  input  logic signed [31:0] f_re_i,
  input  logic signed [31:0] f_im_i,
  input  logic signed [9:0]  p_i,
  output logic signed [31:0] re_o,
  output logic signed [31:0] im_o
);

  logic signed [63:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [9:0]  p_q;
  logic signed [31:0] re_q, im_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= w_re_i * f_re_i;
      pb_q <= w_im_i * f_im_i;
      pc_q <= w_re_i * f_im_i;
      pd_q <= w_im_i * f_re_i;
      p_q  <= p_i;
      re_q <= pwf_pkg::scale_out(pa_q - pb_q, p_q);
      im_q <= pwf_pkg::scale_out(pc_q + pd_q, p_q);
    end
  end

  assign re_o = re_q;
  assign im_o = im_q;

endmodule

/* sv/plane_wave_field_eval_core.sv */
// The delay from item accept to result valid does not depend on the CORDIC stage count.
// Throughput: one item per cycle while the output is not stalled; the pipeline holds up to 42 items.
// Latency is set by the exponential series chain (ten Horner cells, three stages each).
// Reset (async, active low) clears the valid pipeline and all configuration registers.
// ----------------------------------------------------------------------------
// plane_wave_field_eval_core
// Plane-wave E and H field evaluation at one point per item, fully pipelined.
// ----------------------------------------------------------------------------
module plane_wave_field_eval_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] ex_re_o,
  output logic signed [31:0] ex_im_o,
  output logic signed [31:0] ey_re_o,
  output logic signed [31:0] ey_im_o,
  output logic signed [31:0] ez_re_o,
  output logic signed [31:0] ez_im_o,
  output logic signed [31:0] hx_re_o,
  output logic signed [31:0] hx_im_o,
  output logic signed [31:0] hy_re_o,
  output logic signed [31:0] hy_im_o,
  output logic signed [31:0] hz_re_o,
  output logic signed [31:0] hz_im_o
);

  localparam int unsigned N = pwf_pkg::CordicStages;
  localparam int unsigned D = pwf_pkg::CordicDelay;

  logic [63:0] wavenumber_q, admittance_q;
  logic [63:0] amp_q [3];
  logic [62:0] direction_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wavenumber_q <= '0;
      admittance_q <= '0;
      amp_q[0]     <= '0;
      amp_q[1]     <= '0;
      amp_q[2]     <= '0;
      direction_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (pwf_pkg::cfg_idx_e'(cfg_index_i))
        pwf_pkg::CFG_WAVENUMBER: wavenumber_q <= cfg_data_i;
        pwf_pkg::CFG_ADMITTANCE: admittance_q <= cfg_data_i;
        pwf_pkg::CFG_AMP_X:      amp_q[0]     <= cfg_data_i;
        pwf_pkg::CFG_AMP_Y:      amp_q[1]     <= cfg_data_i;
        pwf_pkg::CFG_AMP_Z:      amp_q[2]     <= cfg_data_i;
        pwf_pkg::CFG_DIRECTION:  direction_q  <= cfg_data_i[62:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] kr, ki, yr, yi;
  logic signed [20:0] n  [3];
  logic signed [31:0] er [3];
  logic signed [31:0] ei [3];
  logic signed [31:0] pos [3];

  assign kr = $signed(wavenumber_q[63:32]);
  assign ki = $signed(wavenumber_q[31:0]);
  assign yr = $signed(admittance_q[63:32]);
  assign yi = $signed(admittance_q[31:0]);
  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign n[i]  = $signed(direction_q[21*i +: 21]);
    assign er[i] = $signed(amp_q[i][63:32]);
    assign ei[i] = $signed(amp_q[i][31:0]);
  end

  // handshake and valid pipeline
  logic [pwf_pkg::PipeDepth-1:0] vld_q;
  logic adv;

  assign adv         = !(vld_q[pwf_pkg::PipeDepth-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[pwf_pkg::PipeDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[pwf_pkg::PipeDepth-2:0], in_valid_i};
    end
  end

  // dot product, phase and exponent front end
  logic signed [52:0] prod1_q [3];
  logic signed [54:0] sum2;
  logic signed [35:0] sh2;
  logic signed [31:0] s_q;
  logic signed [63:0] theta_q, ek_q;
  logic [61:0]        ph_hi_prod, ph_lo_prod;
  logic [31:0]        phlo_q;
  logic [29:0]        phhi_q;
  logic signed [63:0] e_sat;
  logic signed [39:0] neg_e;
  logic signed [31:0] u24_q;
  logic [31:0]        ph, phs, phf;
  logic               ph_neg;
  pwf_pkg::cordic_t   c0_q;
  logic signed [63:0] tprod_q;
  logic signed [33:0] t6;
  logic signed [9:0]  p_q;
  logic [53:0]        yprod_q;
  logic [29:0]        y_q, y2_q;

  assign sum2       = prod1_q[0] + prod1_q[1] + prod1_q[2];
  assign sh2        = 36'(sum2 >>> 19);
  assign ph_hi_prod = theta_q[63:32] * pwf_pkg::Inv2Pi;
  assign ph_lo_prod = theta_q[31:0] * pwf_pkg::Inv2Pi;
  assign e_sat      = (ek_q > pwf_pkg::ExpLim) ? pwf_pkg::ExpLim :
                      (ek_q < -pwf_pkg::ExpLim) ? -pwf_pkg::ExpLim : ek_q;
  assign neg_e      = -40'(e_sat);
  assign ph         = phlo_q + {2'b00, phhi_q};
  assign phs        = ph + 32'h4000_0000;
  assign ph_neg     = phs[31];
  assign phf        = ph_neg ? (ph ^ 32'h8000_0000) : ph;
  assign t6         = tprod_q[63:30];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prod1_q[i] <= n[i] * pos[i];
      end
      s_q     <= pwf_pkg::sat32(64'(sh2));
      theta_q <= kr * s_q;
      ek_q    <= ki * s_q;
      phlo_q  <= ph_hi_prod[31:0];
      phhi_q  <= ph_lo_prod[61:32];
      u24_q   <= neg_e[39:8];
      c0_q    <= '{neg: ph_neg, x: pwf_pkg::KGain, y: 34'sd0, z: 34'(signed'(phf))};
      tprod_q <= u24_q * pwf_pkg::Log2E;
      p_q     <= t6[33:24];
      yprod_q <= t6[23:0] * pwf_pkg::Ln2;
      y_q     <= yprod_q[53:24];
      y2_q    <= y_q;
    end
  end

  // CORDIC chain
  pwf_pkg::cordic_t cd [N+1];
  assign cd[0] = c0_q;

  for (genvar k = 0; k < N; k++) begin : g_cordic
    pwf_cordic_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .stage_i(5'(k)),
      .d_i    (cd[k]),
      .d_o    (cd[k+1])
    );
  end

  logic signed [33:0] cx_fold_q, cy_fold_q, cx_al, cy_al;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_fold_q <= cd[N].neg ? -cd[N].x : cd[N].x;
      cy_fold_q <= cd[N].neg ? -cd[N].y : cd[N].y;
    end
  end

  if (D > 0) begin : g_cdly
    logic signed [33:0] cx_dly_q [D];
    logic signed [33:0] cy_dly_q [D];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cx_dly_q[0] <= cx_fold_q;
        cy_dly_q[0] <= cy_fold_q;
        for (int j = 1; j < D; j++) begin
          cx_dly_q[j] <= cx_dly_q[j-1];
          cy_dly_q[j] <= cy_dly_q[j-1];
        end
      end
    end
    assign cx_al = cx_dly_q[D-1];
    assign cy_al = cy_dly_q[D-1];
  end else begin : g_cnodly
    assign cx_al = cx_fold_q;
    assign cy_al = cy_fold_q;
  end

  // exponential series chain
  pwf_pkg::horner_t hn [pwf_pkg::ExpTerms+1];
  assign hn[0] = '{y: y2_q, r: pwf_pkg::HornOne};

  for (genvar k = 0; k < pwf_pkg::ExpTerms; k++) begin : g_horner
    pwf_horner_cell u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .term_i(4'(pwf_pkg::ExpTerms - k)),
      .d_i   (hn[k]),
      .d_o   (hn[k+1])
    );
  end

  // phase factor
  logic signed [66:0] fpr_q, fpi_q;
  logic signed [31:0] fr_q, fi_q;
  logic signed [9:0]  p_dly_q [pwf_pkg::PDelay];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fpr_q <= cx_al * $signed({1'b0, hn[pwf_pkg::ExpTerms].r});
      fpi_q <= cy_al * $signed({1'b0, hn[pwf_pkg::ExpTerms].r});
      fr_q  <= fpr_q[63:32];
      fi_q  <= fpi_q[63:32];
      p_dly_q[0] <= p_q;
      for (int j = 1; j < pwf_pkg::PDelay; j++) begin
        p_dly_q[j] <= p_dly_q[j-1];
      end
    end
  end

  // H weights from configuration: Y * (n x E0)
  logic signed [31:0] cr_q [3];
  logic signed [31:0] ci_q [3];
  logic signed [31:0] w_re_q [3];
  logic signed [31:0] w_im_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int A = (i + 1) % 3;
    localparam int B = (i + 2) % 3;
    logic signed [53:0] dr, di;
    logic signed [34:0] sr, si;
    logic signed [64:0] wr, wi;
    logic signed [48:0] wrs, wis;
    assign dr  = n[A] * er[B] - n[B] * er[A];
    assign di  = n[A] * ei[B] - n[B] * ei[A];
    assign sr  = 35'(dr >>> 19);
    assign si  = 35'(di >>> 19);
    assign wr  = yr * cr_q[i] - yi * ci_q[i];
    assign wi  = yr * ci_q[i] + yi * cr_q[i];
    assign wrs = 49'(wr >>> 16);
    assign wis = 49'(wi >>> 16);
    always_ff @(posedge clk_i) begin
      cr_q[i]   <= (sr > 35'sd2147483647) ? 32'sd2147483647 :
                   (sr < -35'sd2147483647) ? -32'sd2147483647 : sr[31:0];
      ci_q[i]   <= (si > 35'sd2147483647) ? 32'sd2147483647 :
                   (si < -35'sd2147483647) ? -32'sd2147483647 : si[31:0];
      w_re_q[i] <= pwf_pkg::sat32(64'(wrs));
      w_im_q[i] <= pwf_pkg::sat32(64'(wis));
    end
  end

  // output fields
  logic signed [31:0] e_re [3];
  logic signed [31:0] e_im [3];
  logic signed [31:0] h_re [3];
  logic signed [31:0] h_im [3];

  for (genvar i = 0; i < 3; i++) begin : g_out
    pwf_field u_e (
      .clk_i (clk_i),
      .en_i  (adv),
      .w_re_i(er[i]),
      .w_im_i(ei[i]),
      .f_re_i(fr_q),
      .f_im_i(fi_q),
      .p_i   (p_dly_q[pwf_pkg::PDelay-1]),
      .re_o  (e_re[i]),
      .im_o  (e_im[i])
    );
    pwf_field u_h (
      .clk_i (clk_i),
      .en_i  (adv),
      .w_re_i(w_re_q[i]),
      .w_im_i(w_im_q[i]),
      .f_re_i(fr_q),
      .f_im_i(fi_q),
      .p_i   (p_dly_q[pwf_pkg::PDelay-1]),
      .re_o  (h_re[i]),
      .im_o  (h_im[i])
    );
  end

  assign ex_re_o = e_re[0];
  assign ex_im_o = e_im[0];
  assign ey_re_o = e_re[1];
  assign ey_im_o = e_im[1];
  assign ez_re_o = e_re[2];
  assign ez_im_o = e_im[2];
  assign hx_re_o = h_re[0];
  assign hx_im_o = h_im[0];
  assign hy_re_o = h_re[1];
  assign hy_im_o = h_im[1];
  assign hz_re_o = h_re[2];
  assign hz_im_o = h_im[2];

endmodule

/* sv/pwf_checker.sv */
// ----------------------------------------------------------------------------
// pwf_checker
// Port-level checks of the plane-wave field evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pwf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_ready_o,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] ex_re_o,
  input logic [31:0] hz_im_o
);

  // input side stalls exactly when a result is held back
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output backpressure");

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration port not ready");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ex_re_o) && $stable(hz_im_o))
    else $error("stalled item changed");

endmodule

bind plane_wave_field_eval_core pwf_checker u_pwf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .cfg_ready_o(cfg_ready_o),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .ex_re_o    (ex_re_o),
  .hz_im_o    (hz_im_o)
);

/* tb/sv/tb_plane_wave_field_eval_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_plane_wave_field_eval_core
// Self-checking bench: drives points through the evaluator under random
// input gaps and output stalls, predicts E and H in fixed point, and checks
// every field of every result in order.
// ----------------------------------------------------------------------------
module tb_plane_wave_field_eval_core;

  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;
  localparam int         CycleLimit  = 600000;
  localparam longint     Q32Max      = 64'sd2147483647;
  localparam longint     Q32Min      = -64'sd2147483648;

  typedef logic [11:0][31:0] fields_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [63:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [31:0] pos_z_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] ex_re_o, ex_im_o, ey_re_o, ey_im_o, ez_re_o, ez_im_o;
  logic signed [31:0] hx_re_o, hx_im_o, hy_re_o, hy_im_o, hz_re_o, hz_im_o;

  logic [63:0] wavenum_q, admit_q, amp_q [3], dir_q;
  fields_t     field_q [$];
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 1'b0;

  plane_wave_field_eval_core dut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL plane_wave_field_eval_core");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && !calm && ($urandom_range(99) < 29);
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [31:0] to_q824(longint v, longint p);
    longint sh, r;
    int     k;
    sh = 20 - p;
    if (sh >= 0) begin
      r = clamp(v >>> (sh > 62 ? 62 : sh), Q32Min, Q32Max);
    end else begin
      k = int'(-sh);
      if (k > 31) r = v > 0 ? Q32Max : (v < 0 ? Q32Min : 0);
      else if (v > (Q32Max >>> k)) r = Q32Max;
      else if (v < -(64'sd1 <<< (31 - k))) r = Q32Min;
      else r = v <<< k;
    end
    return r[31:0];
  endfunction

  function automatic fields_t eval_field(logic [31:0] px, logic [31:0] py,
                                         logic [31:0] pz);
    longint      n [3], er [3], ei [3], cr [3], ci [3], pos [3];
    longint      kr, ki, yr, yi, s, theta, zc, cx, cy, dx, dy, e, u24, t, p;
    longint      fr, fi, wr, wi;
    logic [63:0] ut, ph64, fp, yv, r;
    logic [31:0] ph;
    bit          neg;
    int          a, b;
    fields_t     o;
    kr = longint'(signed'(wavenum_q[63:32]));
    ki = longint'(signed'(wavenum_q[31:0]));
    yr = longint'(signed'(admit_q[63:32]));
    yi = longint'(signed'(admit_q[31:0]));
    pos[0] = longint'(signed'(px));
    pos[1] = longint'(signed'(py));
    pos[2] = longint'(signed'(pz));
    s = 0;
    for (int i = 0; i < 3; i++) begin
      n[i]  = longint'(signed'(dir_q[21*i +: 21]));
      er[i] = longint'(signed'(amp_q[i][63:32]));
      ei[i] = longint'(signed'(amp_q[i][31:0]));
      s += n[i] * pos[i];
    end
    s = clamp(s >>> 19, Q32Min, Q32Max);

    theta = kr * s;
    ut = theta;
    ph64 = ut[63:32] * 64'd683565276 + ((ut[31:0] * 64'd683565276) >> 32);
    ph = ph64[31:0];
    neg = ph[31] ^ ph[30];
    if (neg) ph = ph + 32'h8000_0000;
    zc = longint'(signed'(ph));
    cx = 652032875;
    cy = 0;
    for (int i = 0; i < pwf_pkg::CordicStages && i < 32; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (zc >= 0) begin
        cx -= dx; cy += dy; zc -= longint'(pwf_pkg::AtanTurns[i]);
      end else begin
        cx += dx; cy -= dy; zc += longint'(pwf_pkg::AtanTurns[i]);
      end
    end
    if (neg) begin
      cx = -cx; cy = -cy;
    end

    e = clamp(ki * s, -(64'sd64 <<< 32), 64'sd64 <<< 32);
    u24 = (-e) >>> 8;
    t = (u24 * 64'sd1549082005) >>> 30;
    p = t >>> 24;
    fp = {40'd0, t[23:0]};
    yv = (fp * 64'd744261118) >> 24;
    r = 64'd1 << 30;
    for (int i = pwf_pkg::ExpTerms; i >= 1; i--) r = (64'd1 << 30) + ((r * yv) >> 30) / i;
    fr = (cx * longint'(r)) >>> 32;
    fi = (cy * longint'(r)) >>> 32;

    for (int i = 0; i < 3; i++) begin
      a = (i + 1) % 3;
      b = (i + 2) % 3;
      cr[i] = clamp((n[a] * er[b] - n[b] * er[a]) >>> 19, -Q32Max, Q32Max);
      ci[i] = clamp((n[a] * ei[b] - n[b] * ei[a]) >>> 19, -Q32Max, Q32Max);
    end
    for (int i = 0; i < 3; i++) begin
      o[2*i]     = to_q824(er[i] * fr - ei[i] * fi, p);
      o[2*i + 1] = to_q824(er[i] * fi + ei[i] * fr, p);
      wr = clamp((yr * cr[i] - yi * ci[i]) >>> 16, Q32Min, Q32Max);
      wi = clamp((yr * ci[i] + yi * cr[i]) >>> 16, Q32Min, Q32Max);
      o[6 + 2*i] = to_q824(wr * fr - wi * fi, p);
      o[7 + 2*i] = to_q824(wr * fi + wi * fr, p);
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    fields_t got, want;
    string   names [12];
    names = '{"ex_re", "ex_im", "ey_re", "ey_im", "ez_re", "ez_im",
              "hx_re", "hx_im", "hy_re", "hy_im", "hz_re", "hz_im"};
    got = {hz_im_o, hz_re_o, hy_im_o, hy_re_o, hx_im_o, hx_re_o,
           ez_im_o, ez_re_o, ey_im_o, ey_re_o, ex_im_o, ex_re_o};
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (field_q.size() == 0) begin
        report_mismatch("unexpected item", got[0], '0);
      end else begin
        want = field_q.pop_front();
        for (int i = 0; i < 12; i++)
          if (got[i] !== want[i]) report_mismatch(names[i], got[i], want[i]);
      end
    end
  end

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    in_valid_i <= 1'b1;
    pos_x_i <= px;
    pos_y_i <= py;
    pos_z_i <= pz;
    do @(posedge clk_i); while (in_stall_o);
    field_q.push_back(eval_field(px, py, pz));
    if (!calm && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 29);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (field_q.size() != 0) @(posedge clk_i);
    repeat (pwf_pkg::PipeDepth + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      pwf_pkg::CFG_WAVENUMBER: wavenum_q = data;
      pwf_pkg::CFG_ADMITTANCE: admit_q = data;
      pwf_pkg::CFG_AMP_X:      amp_q[0] = data;
      pwf_pkg::CFG_AMP_Y:      amp_q[1] = data;
      pwf_pkg::CFG_AMP_Z:      amp_q[2] = data;
      pwf_pkg::CFG_DIRECTION:  dir_q = {1'b0, data[62:0]};
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_field(int bits);
    logic signed [31:0] v;
    v = $urandom;
    return bits >= 32 ? v : v >>> (32 - bits);
  endfunction

  function automatic logic [63:0] rnd_dir(bit full);
    logic [62:0] d;
    for (int i = 0; i < 3; i++) d[21*i +: 21] = full ? 21'($urandom) : 21'(rnd_field(20));
    return {1'b0, d};
  endfunction

  // mostly physical settings, some raw full-range words
  task automatic random_setup();
    bit full;
    full = $urandom_range(99) < 25;
    write_reg(pwf_pkg::CFG_WAVENUMBER,
              full ? {$urandom, $urandom} : {rnd_field(22), rnd_field(13)});
    write_reg(pwf_pkg::CFG_ADMITTANCE,
              full ? {$urandom, $urandom} : {rnd_field(14), rnd_field(12)});
    write_reg(pwf_pkg::CFG_AMP_X, full ? {$urandom, $urandom} : {rnd_field(19), rnd_field(19)});
    write_reg(pwf_pkg::CFG_AMP_Y, full ? {$urandom, $urandom} : {rnd_field(19), rnd_field(19)});
    write_reg(pwf_pkg::CFG_AMP_Z, full ? {$urandom, $urandom} : {rnd_field(19), rnd_field(19)});
    write_reg(pwf_pkg::CFG_DIRECTION, rnd_dir(full));
  endtask

  task automatic send_random_point();
    if ($urandom_range(99) < 15) send_point($urandom, $urandom, $urandom);
    else send_point(rnd_field(22), rnd_field(22), rnd_field(22));
  endtask

  task automatic test_reset_values();
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h0, 32'h0);
    drain();
  endtask

  task automatic test_directed_extremes();
    write_reg(pwf_pkg::CFG_WAVENUMBER, {32'h0006_0000, 32'h0000_1000});
    write_reg(pwf_pkg::CFG_ADMITTANCE, {32'h0000_0800, 32'hFFFF_FC00});
    write_reg(pwf_pkg::CFG_AMP_X, {32'h0001_0000, 32'h0000_0000});
    write_reg(pwf_pkg::CFG_AMP_Y, {32'h0000_0000, 32'h0001_0000});
    write_reg(pwf_pkg::CFG_AMP_Z, {32'hFFFF_0000, 32'h0000_8000});
    write_reg(pwf_pkg::CFG_DIRECTION, {1'b0, 21'd0, 21'd0, 21'h0_7FFFF});
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h0);
    drain();
    // non-unit direction, every slot at its extremes
    write_reg(pwf_pkg::CFG_DIRECTION, {1'b0, 21'h10_0000, 21'h0F_FFFF, 21'h10_0000});
    send_point(32'h0003_0000, 32'hFFFD_0000, 32'h0000_1234);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    // strong growth and strong decay
    write_reg(pwf_pkg::CFG_DIRECTION, {1'b0, 21'd0, 21'd0, 21'h0_7FFFF});
    write_reg(pwf_pkg::CFG_WAVENUMBER, {32'h0001_0000, 32'h7FFF_FFFF});
    send_point(32'h0100_0000, 32'h0, 32'h0);
    send_point(32'hFF00_0000, 32'h0, 32'h0);
    send_point(32'h0000_0100, 32'h0, 32'h0);
    drain();
    // large phase
    write_reg(pwf_pkg::CFG_WAVENUMBER, {32'h7FFF_FFFF, 32'h0});
    send_point(32'h7FFF_0000, 32'h0, 32'h0);
    send_point(32'h8000_1000, 32'h0, 32'h0);
    drain();
    // zero admittance; spare indexes must be ignored
    write_reg(pwf_pkg::CFG_WAVENUMBER, {32'h0003_0000, 32'hFFFF_F000});
    write_reg(pwf_pkg::CFG_ADMITTANCE, 64'h0);
    write_reg(CFG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_SPARE_B, 64'h1234_5678_9ABC_DEF0);
    send_point(32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000);
    send_point(32'h0010_0000, 32'h0, 32'h0);
    drain();
    write_reg(pwf_pkg::CFG_WAVENUMBER, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(pwf_pkg::CFG_ADMITTANCE, 64'h8000_0000_8000_0000);
    write_reg(pwf_pkg::CFG_AMP_X, 64'h7FFF_FFFF_7FFF_FFFF);
    write_reg(pwf_pkg::CFG_AMP_Y, 64'h8000_0000_8000_0000);
    write_reg(pwf_pkg::CFG_AMP_Z, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(pwf_pkg::CFG_DIRECTION, 64'hFFFF_FFFF_FFFF_FFFF);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_point(32'h0, 32'h0, 32'h0);
    drain();
  endtask

  task automatic test_random_points();
    for (int ph = 0; ph < 14; ph++) begin
      random_setup();
      calm = (ph == 3);
      for (int i = 0; i < 100; i++) begin
        if (ph == 6 && i == 50) drain();
        send_random_point();
      end
      calm = 1'b0;
      drain();
    end
  endtask

  initial begin
    wavenum_q = '0;
    admit_q = '0;
    amp_q = '{default: '0};
    dir_q = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed_extremes();
    test_random_points();
    while (field_q.size() != 0) @(posedge clk_i);
    repeat (pwf_pkg::PipeDepth + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS plane_wave_field_eval_core");
    end else begin
      $display("FAIL plane_wave_field_eval_core");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/pwf_pkg.sv
sv/pwf_cordic_cell.sv
sv/pwf_horner_cell.sv
sv/pwf_field.sv
sv/plane_wave_field_eval_core.sv
sv/pwf_checker.sv
tb/sv/tb_plane_wave_field_eval_core.sv
